// ===== rtl/lsp_pkg.sv =====
// Package for the lane strip peak finder: image geometry, field widths and
// register address codes. No dependencies; imported by lane_strip_peak_finder.
`default_nettype none

package lsp_pkg;

    // Frame geometry.
    localparam int IMAGE_WIDTH  = 320;
    localparam int IMAGE_HEIGHT = 240;
    localparam int STRIP_COUNT  = 20;

    // Rows in one strip and the split point between the two halves.
    localparam int STRIP_ROWS = IMAGE_HEIGHT / STRIP_COUNT;
    localparam int HALF_COLS  = IMAGE_WIDTH / 2;

    // Counter widths derived from the geometry.
    localparam int COL_W     = $clog2(IMAGE_WIDTH);
    localparam int ROW_W     = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
    localparam int SROW_W    = (STRIP_ROWS > 1) ? $clog2(STRIP_ROWS) : 1;
    localparam int STRIP_MAX = (STRIP_ROWS > 0) ? (IMAGE_HEIGHT - 1) / STRIP_ROWS : 0;
    localparam int STRIP_W   = (STRIP_MAX > 0) ? $clog2(STRIP_MAX + 1) : 1;

    // Payload widths fixed by the interface.
    localparam int PIX_W      = 8;
    localparam int HIT_W      = 4;
    localparam int STRIP_IX_W = 5;
    localparam int LCOL_W     = 8;
    localparam int RCOL_W     = 9;
    localparam int PTHR_W     = 12;

    localparam logic [HIT_W-1:0] HIT_MAX   = 4'd15;
    localparam logic [PIX_W-1:0] SUM_SCALE = 8'd255;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_LIGHT_THR = 2'd0;
    localparam logic [1:0] REG_INVERT    = 2'd1;
    localparam logic [1:0] REG_PEAK_THR  = 2'd2;

    localparam logic [PIX_W-1:0]  LIGHT_THR_RST = 8'd180;
    localparam logic              INVERT_RST    = 1'b1;
    localparam logic [PTHR_W-1:0] PEAK_THR_RST  = 12'd2500;

    // Per-pixel tags carried from the input register to the result logic.
    typedef struct packed {
        logic                 hit;
        logic [COL_W-1:0]     col;
        logic                 first_row;
        logic                 scan_row;
        logic                 last_col;
        logic [STRIP_W-1:0]   strip;
    } t_pix_tag;

endpackage

`default_nettype wire

// ===== rtl/lane_strip_peak_finder.sv =====
// Top level of the lane strip peak finder: pixel counters, column count memory,
// peak tracking and the APB register file. Depends on lsp_pkg.
`default_nettype none

// Lane strip peak finder. Lightness pixels of a 320 x 240 bird's-eye frame
// arrive in raster order, one transfer each, and the block accepts one pixel
// in every clock cycle when the result side keeps up. Each pixel is turned
// into a hit by comparing it with the lightness threshold (inverted mode: at
// or below the level is a hit). Hits are counted per column over strips of
// 12 rows in a 320-entry count memory; the read of a column count is issued
// when the pixel is accepted and the updated count is written back as the
// pixel retires from the tag stage, so the memory's single read and write
// port set the rate of one pixel per cycle. While the last row of a strip
// passes, the left and right halves keep the first column with the largest
// count. After the last pixel of a strip, one result transfer carries the
// strip index and both peaks; a peak is flagged as found when its count
// times 255 exceeds the peak threshold. A result enters the output register
// when its pixel retires from the tag stage, and the input keeps flowing
// while a result waits to be taken unless another result is ready behind
// it. Asserting frame_start on a pixel restarts the frame at row 0, column 0
// and drops any strip in progress. The user must write registers through the
// APB port only while no pixel is in flight; the block does not enforce it.
module lane_strip_peak_finder import lsp_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    // Pixel input channel.
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [PIX_W-1:0]        i_lightness,
    input  wire logic                    i_frame_start,

    // Strip result channel.
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [STRIP_IX_W-1:0]        o_strip_index,
    output logic                         o_left_found,
    output logic [LCOL_W-1:0]            o_left_column,
    output logic [HIT_W-1:0]             o_left_hits,
    output logic                         o_right_found,
    output logic [RCOL_W-1:0]            o_right_column,
    output logic [HIT_W-1:0]             o_right_hits,

    // Configuration port.
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_W-1:0]      paddr,
    input  wire logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  r_light_thr;
    logic              r_invert;
    logic [PTHR_W-1:0] r_peak_thr;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_thr <= LIGHT_THR_RST;
            r_invert    <= INVERT_RST;
            r_peak_thr  <= PEAK_THR_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LIGHT_THR: r_light_thr <= pwdata[PIX_W-1:0];
                REG_INVERT:    r_invert    <= pwdata[0];
                REG_PEAK_THR:  r_peak_thr  <= pwdata[PTHR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LIGHT_THR: prdata = PDATA_W'(r_light_thr);
            REG_INVERT:    prdata = PDATA_W'(r_invert);
            REG_PEAK_THR:  prdata = PDATA_W'(r_peak_thr);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. The tag stage holds one accepted pixel; it retires when
    // it makes no result or when the output register is free.
    // ------------------------------------------------------------------
    logic     r_s1_valid;
    t_pix_tag r_s1_tag;
    logic     in_xfer;
    logic     out_free;
    logic     s1_makes_result;
    logic     s1_fire;

    assign out_free        = !o_valid || !i_stall;
    assign s1_makes_result = r_s1_tag.scan_row && r_s1_tag.last_col && (STRIP_ROWS > 0);
    assign s1_fire         = r_s1_valid && (!s1_makes_result || out_free);
    assign o_stall         = r_s1_valid && !s1_fire;
    assign in_xfer         = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Raster position. Row-in-strip and strip counters run beside the row
    // counter so that no division is needed.
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [SROW_W-1:0]  r_srow;
    logic [STRIP_W-1:0] r_strip;
    logic [COL_W-1:0]   cur_col;
    logic [ROW_W-1:0]   cur_row;
    logic [SROW_W-1:0]  cur_srow;
    logic [STRIP_W-1:0] cur_strip;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;
    logic [SROW_W-1:0]  n_srow;
    logic [STRIP_W-1:0] n_strip;
    logic               cur_last_col;
    logic               cur_last_row;
    logic               cur_last_srow;
    t_pix_tag           cur_tag;

    always_comb begin
        cur_col   = i_frame_start ? '0 : r_col;
        cur_row   = i_frame_start ? '0 : r_row;
        cur_srow  = i_frame_start ? '0 : r_srow;
        cur_strip = i_frame_start ? '0 : r_strip;

        cur_last_col  = (cur_col == COL_W'(IMAGE_WIDTH - 1));
        cur_last_row  = (cur_row == ROW_W'(IMAGE_HEIGHT - 1));
        cur_last_srow = (STRIP_ROWS > 0) && (cur_srow == SROW_W'(STRIP_ROWS - 1));

        n_col   = cur_col;
        n_row   = cur_row;
        n_srow  = cur_srow;
        n_strip = cur_strip;
        if (cur_last_col) begin
            n_col = '0;
            if (cur_last_row) begin
                n_row   = '0;
                n_srow  = '0;
                n_strip = '0;
            end else begin
                n_row = cur_row + 1'b1;
                if (cur_last_srow) begin
                    n_srow  = '0;
                    n_strip = cur_strip + 1'b1;
                end else begin
                    n_srow = cur_srow + 1'b1;
                end
            end
        end else begin
            n_col = cur_col + 1'b1;
        end

        if (r_invert) begin
            cur_tag.hit = (i_lightness <= r_light_thr);
        end else begin
            cur_tag.hit = (i_lightness > r_light_thr);
        end
        cur_tag.col       = cur_col;
        cur_tag.first_row = (cur_srow == '0);
        cur_tag.scan_row  = cur_last_srow && (32'(cur_strip) < STRIP_COUNT);
        cur_tag.last_col  = cur_last_col;
        cur_tag.strip     = cur_strip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_srow     <= '0;
            r_strip    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_srow  <= n_srow;
                r_strip <= n_strip;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_tag <= cur_tag;
        end
    end

    // ------------------------------------------------------------------
    // Column count memory. The count of the accepted pixel's column is read
    // on acceptance; the updated count is written when the pixel retires.
    // Two pixels in flight never share a column unless the newer one starts
    // a strip, and a strip's first row does not use the stored count.
    // ------------------------------------------------------------------
    logic [HIT_W-1:0] r_col_hits [IMAGE_WIDTH];
    logic [HIT_W-1:0] r_rd_hits;
    logic [HIT_W:0]   sum_hits;
    logic [HIT_W-1:0] cnt;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd_hits <= r_col_hits[cur_col];
        end
        if (s1_fire && (STRIP_ROWS > 0)) begin
            r_col_hits[r_s1_tag.col] <= cnt;
        end
    end

    always_comb begin
        sum_hits = {1'b0, r_rd_hits} + (HIT_W + 1)'(r_s1_tag.hit);
        if (r_s1_tag.first_row) begin
            cnt = HIT_W'(r_s1_tag.hit);
        end else if (sum_hits > {1'b0, HIT_MAX}) begin
            cnt = HIT_MAX;
        end else begin
            cnt = sum_hits[HIT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Peak tracking over the last row of a strip. The first column of each
    // half restarts the search; later columns win only with a larger count.
    // ------------------------------------------------------------------
    logic [HIT_W-1:0]  r_lbest_hits;
    logic [COL_W-1:0]  r_lbest_col;
    logic [HIT_W-1:0]  r_rbest_hits;
    logic [COL_W-1:0]  r_rbest_col;
    logic [HIT_W-1:0]  n_lbest_hits;
    logic [COL_W-1:0]  n_lbest_col;
    logic [HIT_W-1:0]  n_rbest_hits;
    logic [COL_W-1:0]  n_rbest_col;
    logic              in_left;
    logic [PTHR_W-1:0] lsum;
    logic [PTHR_W-1:0] rsum;

    always_comb begin
        n_lbest_hits = r_lbest_hits;
        n_lbest_col  = r_lbest_col;
        n_rbest_hits = r_rbest_hits;
        n_rbest_col  = r_rbest_col;
        in_left      = (r_s1_tag.col < COL_W'(HALF_COLS));
        if (r_s1_tag.scan_row && (STRIP_ROWS > 0)) begin
            if (in_left) begin
                if ((r_s1_tag.col == '0) || (cnt > r_lbest_hits)) begin
                    n_lbest_hits = cnt;
                    n_lbest_col  = r_s1_tag.col;
                end
            end else begin
                if ((r_s1_tag.col == COL_W'(HALF_COLS)) || (cnt > r_rbest_hits)) begin
                    n_rbest_hits = cnt;
                    n_rbest_col  = r_s1_tag.col;
                end
            end
        end
        // Count times 255 fits in 12 bits for any 4-bit count.
        lsum = PTHR_W'(n_lbest_hits) * PTHR_W'(SUM_SCALE);
        rsum = PTHR_W'(n_rbest_hits) * PTHR_W'(SUM_SCALE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lbest_hits <= '0;
            r_lbest_col  <= '0;
            r_rbest_hits <= '0;
            r_rbest_col  <= COL_W'(HALF_COLS);
        end else if (s1_fire) begin
            r_lbest_hits <= n_lbest_hits;
            r_lbest_col  <= n_lbest_col;
            r_rbest_hits <= n_rbest_hits;
            r_rbest_col  <= n_rbest_col;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (s1_fire && s1_makes_result) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_makes_result) begin
            o_strip_index  <= STRIP_IX_W'(r_s1_tag.strip);
            o_left_found   <= (lsum > r_peak_thr);
            o_left_column  <= LCOL_W'(n_lbest_col);
            o_left_hits    <= n_lbest_hits;
            o_right_found  <= (rsum > r_peak_thr);
            o_right_column <= RCOL_W'(n_rbest_col);
            o_right_hits   <= n_rbest_hits;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_stall_needs_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && s1_makes_result && o_valid && i_stall))
        else $error("input stalled without a blocked result behind it");

    a_strip_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_strip_index) < STRIP_COUNT))
        else $error("result for a strip beyond the last one");

    a_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((32'(o_left_column) < HALF_COLS) && (32'(o_right_column) >= HALF_COLS)))
        else $error("peak column outside its half");

    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((32'(o_left_hits) <= STRIP_ROWS) && (32'(o_right_hits) <= STRIP_ROWS)))
        else $error("peak count larger than the rows in a strip");

endmodule

`default_nettype wire
